FILE: sv/gsa_pkg.sv
// Shared types, codes and helpers for the generational slot allocator.
package gsa_pkg;

   localparam int unsigned GSA_NUM_SLOTS = 1024;
   localparam int unsigned SLOT_W        = 10;
   localparam int unsigned GEN_W         = 32;
   localparam int unsigned HOST_W        = 32;

   typedef enum logic [1:0] {
      OP_ALLOC   = 2'd0,
      OP_RELEASE = 2'd1,
      OP_CHECK   = 2'd2,
      OP_CLEAR   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STS_OK       = 2'd0,
      STS_FULL     = 2'd1,
      STS_INVALID  = 2'd2,
      STS_NOT_LIVE = 2'd3
   } status_type;

   // Generation bump; zero is never a valid generation.
   function automatic logic [GEN_W-1:0] gen_advance(input logic [GEN_W-1:0] g);
      logic [GEN_W-1:0] n;
      n = g + GEN_W'(1);
      return (n == '0) ? GEN_W'(1) : n;
   endfunction

endpackage

FILE: sv/gsa_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
module gsa_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/generational_slot_allocator_unit.sv
// Generational slot allocator: handle table with free list, top level.
//
// Request channel: start with req_op and the handle fields is taken at a
// clock edge where busy is low. Ops: allocate, release, check handle, clear.
// Response channel: rsp_valid pulses for one cycle with rsp_status,
// rsp_out_slot and rsp_out_generation; the receiver cannot stall, so the
// response must be captured in that cycle.
// Allocate, release and check pass through one execute state with busy
// high; the response strobe is registered from it and busy is low while it
// is shown, so a new request can be taken then. The slot memory is read in
// the accept cycle and written back in the next one. Clear walks every slot
// handed out so far, one per cycle through the read and write ports of the
// slot memory; the response strobe comes in the same cycle as busy drops.
// Config: csr_wdata sets the host id when csr_valid is high (always ready);
// write it only while no request is outstanding.
// Reset: synchronous, clears the allocator to an empty table with host id 1.
// No memory clearing pass: slots past the used count read as fresh.
module generational_slot_allocator_unit
   import gsa_pkg::*;
#(
   parameter int unsigned NUM_SLOTS = GSA_NUM_SLOTS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_op,
   input  logic              req_handle_set,
   input  logic [HOST_W-1:0] req_handle_host,
   input  logic [SLOT_W-1:0] req_slot_index,
   input  logic [GEN_W-1:0]  req_handle_generation,
   output logic              rsp_valid,
   output logic [1:0]        rsp_status,
   output logic [SLOT_W-1:0] rsp_out_slot,
   output logic [GEN_W-1:0]  rsp_out_generation,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [HOST_W-1:0] csr_wdata
);

   localparam int unsigned IDX_W   = $clog2(NUM_SLOTS);
   localparam int unsigned CNT_W   = $clog2(NUM_SLOTS + 1);
   localparam int unsigned EXT_W   = CNT_W + SLOT_W;
   localparam int unsigned ENTRY_W = GEN_W + 1;
   localparam logic [CNT_W-1:0] SLOT_NONE = CNT_W'(NUM_SLOTS);

   typedef enum logic {ST_IDLE, ST_EXEC} state_type;
   typedef enum logic [1:0] {ALLOC_LIST, ALLOC_FRESH, ALLOC_FULL} alloc_type;

   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   alloc_type         alloc_kind_ff, alloc_kind_in;
   logic              set_ff, set_in;
   logic [HOST_W-1:0] host_ff, host_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [GEN_W-1:0]  hgen_ff, hgen_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic [CNT_W-1:0]  free_head_ff, free_head_in;
   logic [CNT_W-1:0]  used_count_ff, used_count_in;
   logic [HOST_W-1:0] host_id_ff, host_id_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [GEN_W-1:0]  rsp_gen_ff, rsp_gen_in;

   logic               accept;
   logic [EXT_W-1:0]   req_idx_ext;
   logic [EXT_W-1:0]   idx_ext;
   logic [EXT_W-1:0]   ptr_ext;
   logic [CNT_W-1:0]   ptr_plus;
   logic               idx_in_use;
   logic [IDX_W-1:0]   rd_addr;
   logic [IDX_W-1:0]   wr_addr;
   logic               slot_we;
   logic [ENTRY_W-1:0] slot_wdata;
   logic [ENTRY_W-1:0] slot_rdata;
   logic               link_we;
   logic [CNT_W-1:0]   link_wdata;
   logic [CNT_W-1:0]   link_rdata;
   logic [GEN_W-1:0]   rd_gen;
   logic               rd_live;
   logic [GEN_W-1:0]   alloc_gen;

   // {live, generation} per slot
   gsa_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_SLOTS)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (wr_addr),
      .wr_data (slot_wdata),
      .rd_addr (rd_addr),
      .rd_data (slot_rdata)
   );

   // free-list links
   gsa_ram #(.WIDTH(CNT_W), .DEPTH(NUM_SLOTS)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (wr_addr),
      .wr_data (link_wdata),
      .rd_addr (rd_addr),
      .rd_data (link_rdata)
   );

   assign busy        = (state_ff == ST_EXEC);
   assign accept      = start && !busy;
   assign csr_ready   = 1'b1;
   assign req_idx_ext = EXT_W'(req_slot_index);
   assign idx_ext     = EXT_W'(idx_ff);
   assign ptr_ext     = EXT_W'(ptr_ff);
   assign ptr_plus    = ptr_ff + CNT_W'(1);
   assign idx_in_use  = idx_ext < EXT_W'(used_count_ff);
   assign rd_gen      = slot_rdata[GEN_W-1:0];
   assign rd_live     = slot_rdata[GEN_W];
   assign wr_addr     = (op_ff == OP_RELEASE) ? idx_ext[IDX_W-1:0] : ptr_ff[IDX_W-1:0];
   // slots never handed out get generation 1, not the memory contents
   assign alloc_gen   = (alloc_kind_ff == ALLOC_FRESH) ? GEN_W'(1) : rd_gen;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      alloc_kind_in = alloc_kind_ff;
      set_in        = set_ff;
      host_in       = host_ff;
      idx_in        = idx_ff;
      hgen_in       = hgen_ff;
      ptr_in        = ptr_ff;
      free_head_in  = free_head_ff;
      used_count_in = used_count_ff;
      host_id_in    = csr_valid ? csr_wdata : host_id_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_gen_in    = rsp_gen_ff;
      rd_addr       = ptr_plus[IDX_W-1:0];
      slot_we       = 1'b0;
      slot_wdata    = {1'b1, alloc_gen};
      link_we       = 1'b0;
      link_wdata    = free_head_ff;

      case (state_ff)
         ST_IDLE: begin
            rd_addr = '0;
            case (op_type'(req_op))
               OP_ALLOC: begin
                  if (free_head_ff < SLOT_NONE) begin
                     rd_addr = free_head_ff[IDX_W-1:0];
                  end
               end
               OP_RELEASE, OP_CHECK: begin
                  rd_addr = req_idx_ext[IDX_W-1:0];
               end
               default: begin
                  rd_addr = '0;
               end
            endcase
            if (accept) begin
               state_in = ST_EXEC;
               op_in    = op_type'(req_op);
               set_in   = req_handle_set;
               host_in  = req_handle_host;
               idx_in   = req_slot_index;
               hgen_in  = req_handle_generation;
               ptr_in   = '0;
               if (free_head_ff < SLOT_NONE) begin
                  alloc_kind_in = ALLOC_LIST;
                  ptr_in        = free_head_ff;
               end else if (used_count_ff < SLOT_NONE) begin
                  alloc_kind_in = ALLOC_FRESH;
                  ptr_in        = used_count_ff;
               end else begin
                  alloc_kind_in = ALLOC_FULL;
               end
               if (op_type'(req_op) != OP_ALLOC) begin
                  ptr_in = '0;
               end
            end
         end

         ST_EXEC: begin
            rsp_slot_in = idx_ff;
            rsp_gen_in  = '0;
            case (op_ff)
               OP_ALLOC: begin
                  state_in     = ST_IDLE;
                  rsp_valid_in = 1'b1;
                  case (alloc_kind_ff)
                     ALLOC_LIST: begin
                        slot_we       = 1'b1;
                        free_head_in  = (link_rdata > SLOT_NONE) ? SLOT_NONE : link_rdata;
                        rsp_status_in = STS_OK;
                        rsp_slot_in   = ptr_ext[SLOT_W-1:0];
                        rsp_gen_in    = alloc_gen;
                     end
                     ALLOC_FRESH: begin
                        slot_we       = 1'b1;
                        used_count_in = used_count_ff + CNT_W'(1);
                        rsp_status_in = STS_OK;
                        rsp_slot_in   = ptr_ext[SLOT_W-1:0];
                        rsp_gen_in    = alloc_gen;
                     end
                     default: begin
                        rsp_status_in = STS_FULL;
                        rsp_slot_in   = '0;
                     end
                  endcase
               end
               OP_RELEASE: begin
                  state_in     = ST_IDLE;
                  rsp_valid_in = 1'b1;
                  if (idx_in_use && rd_live) begin
                     slot_we       = 1'b1;
                     slot_wdata    = {1'b0, gen_advance(rd_gen)};
                     link_we       = 1'b1;
                     link_wdata    = free_head_ff;
                     free_head_in  = idx_ext[CNT_W-1:0];
                     rsp_status_in = STS_OK;
                  end else begin
                     rsp_status_in = STS_NOT_LIVE;
                  end
               end
               OP_CHECK: begin
                  state_in     = ST_IDLE;
                  rsp_valid_in = 1'b1;
                  if (set_ff && (host_ff == host_id_ff) && idx_in_use && rd_live &&
                      (rd_gen == hgen_ff)) begin
                     rsp_status_in = STS_OK;
                  end else begin
                     rsp_status_in = STS_INVALID;
                  end
               end
               default: begin
                  // clear sweep: write slot ptr while slot ptr+1 is being read
                  rsp_status_in = STS_OK;
                  if (ptr_ff < used_count_ff) begin
                     slot_we    = 1'b1;
                     slot_wdata = {1'b0, rd_live ? gen_advance(rd_gen) : rd_gen};
                     link_we    = 1'b1;
                     link_wdata = (ptr_plus < used_count_ff) ? ptr_plus : SLOT_NONE;
                  end
                  if (ptr_plus >= used_count_ff) begin
                     state_in     = ST_IDLE;
                     rsp_valid_in = 1'b1;
                     free_head_in = (used_count_ff != '0) ? '0 : SLOT_NONE;
                  end else begin
                     ptr_in = ptr_plus;
                  end
               end
            endcase
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         free_head_ff  <= SLOT_NONE;
         used_count_ff <= '0;
         host_id_ff    <= HOST_W'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         free_head_ff  <= free_head_in;
         used_count_ff <= used_count_in;
         host_id_ff    <= host_id_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff         <= op_in;
      alloc_kind_ff <= alloc_kind_in;
      set_ff        <= set_in;
      host_ff       <= host_in;
      idx_ff        <= idx_in;
      hgen_ff       <= hgen_in;
      ptr_ff        <= ptr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_gen_ff    <= rsp_gen_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_out_slot       = rsp_slot_ff;
   assign rsp_out_generation = rsp_gen_ff;

`ifndef ASSERT_OFF
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("request accepted but block not busy next cycle");

   a_rsp_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("responses in back-to-back cycles");

   a_counts_bound: assert property (@(posedge clock) disable iff (reset)
      (used_count_ff <= SLOT_NONE) && (free_head_ff <= SLOT_NONE))
      else $error("used count or free head out of range");

   a_head_in_use: assert property (@(posedge clock) disable iff (reset)
      (free_head_ff != SLOT_NONE) |-> (free_head_ff < used_count_ff))
      else $error("free list head names a slot never handed out");

   a_full_no_gen: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STS_OK)) |-> (rsp_out_generation == '0))
      else $error("failed request returned a generation");
`endif

endmodule
